/* design/agfct_pkg.sv */
// ----------------------------------------------------------------------------
// agfct_pkg
// Shared types, constants and table generators for the gate, filter,
// saturation and tremolo block.
// ----------------------------------------------------------------------------
`default_nettype none

package agfct_pkg;

	// default sizes
	localparam int AGF_SAMPLE_BITS = 24;
	localparam int AGF_SINE_DEPTH  = 256;
	localparam int AGF_TANH_DEPTH  = 1024;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// table word widths
	localparam int TANH_W = 25;
	localparam int SINE_W = 16;

	// tanh table read uses 26 fraction bits of the driven magnitude
	localparam int TANH_POS_FRAC = 26;

	// drive at or below 1.01 in Q4.12 skips the saturation
	localparam logic [15:0] BYPASS_DRIVE = 16'd4137;

	// configuration register indexes
	localparam int REG_IDX_W = 4;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INPUT_GAIN    = 4'd0,
		REG_GATE_THRESH   = 4'd1,
		REG_HP_COEFF      = 4'd2,
		REG_LP_COEFF      = 4'd3,
		REG_DRIVE         = 4'd4,
		REG_OUT_SCALE     = 4'd5,
		REG_TREMOLO_DEPTH = 4'd6,
		REG_TREMOLO_STEP  = 4'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MGAIN,
		ST_GATE,
		ST_MHP,
		ST_HP,
		ST_DIFF,
		ST_MLP,
		ST_LP,
		ST_MDRV,
		ST_TIDX,
		ST_T0,
		ST_T1,
		ST_TDIF,
		ST_TM,
		ST_TC,
		ST_MOUT,
		ST_Y,
		ST_MSIN,
		ST_G,
		ST_MG,
		ST_OUT
	} state_t;

	// Q30 constants for the table generators
	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint Q30_TWO_PI  = 64'sd6746518852;
	localparam longint Q30_PI      = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// long division of non-negative values, quotient truncated
	function automatic longint div_u(input longint n, input longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & 64'sd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// sin of a Q30 angle in [0, 2pi), result Q30
	function automatic longint sin_q30(input longint a_in);
		longint a;
		longint x2;
		longint term;
		longint sum;
		bit     neg;
		a   = a_in;
		neg = 1'b0;
		if (a > Q30_PI) begin
			neg = 1'b1;
			a   = a - Q30_PI;
		end
		if (a > Q30_HALF_PI)
			a = Q30_PI - a;
		x2   = (a * a) >>> 30;
		term = a;
		sum  = a;
		for (int k = 1; k <= 8; k++) begin
			term = div_u((term * x2) >>> 30, longint'((2 * k) * (2 * k + 1)));
			if ((k & 1) != 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		return neg ? -sum : sum;
	endfunction

	// exp(-16 f) for Q30 f in [0, 1], result Q30
	function automatic longint exp_neg16(input longint f);
		longint term;
		longint sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int k = 1; k <= 16; k++) begin
			term = div_u((term * f) >>> 30, longint'(k));
			if ((k & 1) != 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		for (int k = 0; k < 4; k++)
			sum = (sum * sum) >>> 30;
		return sum;
	endfunction

	function automatic longint sine_entry(input int depth, input int i);
		longint s;
		longint m;
		s = sin_q30(div_u(longint'(i) * Q30_TWO_PI, longint'(depth)));
		m = (s < 0) ? -s : s;
		m = (m * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
		return (s < 0) ? -m : m;
	endfunction

	function automatic longint tanh_entry(input int depth, input int i);
		longint e;
		longint den;
		e   = exp_neg16(div_u(longint'(i) <<< 30, longint'(depth)));
		den = Q30_ONE + e;
		return div_u(((Q30_ONE - e) <<< 23) + (den >>> 1), den);
	endfunction

endpackage

`default_nettype wire

/* design/agfct_mul.sv */
// ----------------------------------------------------------------------------
// agfct_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module agfct_mul
	import agfct_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		if (en)
			p_q <= a * b;
	end

endmodule

`default_nettype wire

/* design/agfct_tanh_rom.sv */
// ----------------------------------------------------------------------------
// agfct_tanh_rom
// Constant tanh table, depth+1 entries, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module agfct_tanh_rom
	import agfct_pkg::*;
#(
	parameter int DEPTH = AGF_TANH_DEPTH,
	parameter int AW    = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic [AW-1:0]            addr,
	output logic signed [TANH_W-1:0]      rd_q
);

	typedef logic signed [TANH_W-1:0] tanh_tab_t [DEPTH + 1];

	function automatic tanh_tab_t build_tab();
		tanh_tab_t t;
		for (int i = 0; i <= DEPTH; i++)
			t[i] = TANH_W'(tanh_entry(DEPTH, i));
		return t;
	endfunction

	localparam tanh_tab_t TAB = build_tab();

	always_ff @(posedge clk) begin
		rd_q <= TAB[addr];
	end

endmodule

`default_nettype wire

/* design/agfct_sine_rom.sv */
// ----------------------------------------------------------------------------
// agfct_sine_rom
// Constant LFO sine table, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module agfct_sine_rom
	import agfct_pkg::*;
#(
	parameter int DEPTH = AGF_SINE_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic [AW-1:0]            addr,
	output logic signed [SINE_W-1:0]      rd_q
);

	typedef logic signed [SINE_W-1:0] sine_tab_t [DEPTH];

	function automatic sine_tab_t build_tab();
		sine_tab_t t;
		for (int i = 0; i < DEPTH; i++)
			t[i] = SINE_W'(sine_entry(DEPTH, i));
		return t;
	endfunction

	localparam sine_tab_t TAB = build_tab();

	always_ff @(posedge clk) begin
		rd_q <= TAB[addr];
	end

endmodule

`default_nettype wire

/* design/audio_gate_filter_clip_tremolo.sv */
// ----------------------------------------------------------------------------
// audio_gate_filter_clip_tremolo
// Input gain, noise gate, one-pole high-pass and low-pass, tanh saturation
// and sine tremolo on one sample, sequenced over a single shared multiplier.
// ----------------------------------------------------------------------------
// channel   direction  signals                       contents
// s_*       in         s_tvalid s_tready s_tdata     sample_in
// m_*       out        m_tvalid m_tready m_tdata     sample_out
// wr_*      in         wr_en wr_index wr_data        register writes
//
// each sample runs from acceptance through the sequencer states to the output
// register and back to idle, with eight passes through the shared multiplier
// and two tanh table reads; a new sample is accepted only once back in idle.
// s_tready is high only while the sequencer is idle.
// a result waiting on m_tready holds the sequencer at its last step.
// reset clears filter state, LFO phase and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_gate_filter_clip_tremolo
	import agfct_pkg::*;
#(
	parameter int SAMPLE_BITS      = AGF_SAMPLE_BITS,
	parameter int SINE_TABLE_DEPTH = AGF_SINE_DEPTH,
	parameter int TANH_TABLE_DEPTH = AGF_TANH_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample_in
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // sample_out
	input  wire logic                             wr_en,
	input  wire logic [REG_IDX_W-1:0]             wr_index,
	input  wire logic [31:0]                      wr_data
);

	localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SL  = $clog2(SINE_TABLE_DEPTH);
	localparam int TL  = $clog2(TANH_TABLE_DEPTH);
	localparam int TAW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int FB  = TANH_POS_FRAC - TL;

	localparam logic signed [39:0] OUT_MAX = 40'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [39:0] OUT_MIN = -OUT_MAX - 40'sd1;

	// configuration
	logic [15:0] input_gain_q;
	logic [22:0] gate_threshold_q;
	logic [22:0] hp_coeff_q;
	logic [22:0] lp_coeff_q;
	logic [15:0] drive_q;
	logic [15:0] out_scale_q;
	logic [15:0] tremolo_depth_q;
	logic [31:0] tremolo_step_q;

	// state
	state_t state_q, state_d;
	logic signed [31:0] hp_in_q, hp_out_q, lp_q;
	logic [31:0]        phase_q;
	logic               m_tvalid_q;

	// working registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [31:0]            m_q;
	logic signed [32:0]            diff_q;
	logic [35:0]                   mag_q;
	logic                          neg_q;
	logic signed [TANH_W-1:0]      t0_q;
	logic signed [TANH_W-1:0]      tdif_q;
	logic signed [31:0]            c_q;
	logic signed [35:0]            y_q;
	logic signed [18:0]            g_q;
	logic [SAMPLE_BITS-1:0]        m_data_q;

	// multiplier and tables
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] p_q;
	logic [TAW-1:0]            tanh_addr;
	logic signed [TANH_W-1:0]  tanh_q;
	logic signed [SINE_W-1:0]  sine_q;
	logic                      out_load;

	agfct_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	agfct_tanh_rom #(
		.DEPTH (TANH_TABLE_DEPTH),
		.AW    (TAW)
	) u_tanh (
		.clk  (clk),
		.addr (tanh_addr),
		.rd_q (tanh_q)
	);

	agfct_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH),
		.AW    (SL)
	) u_sine (
		.clk  (clk),
		.addr (phase_q[31:32-SL]),
		.rd_q (sine_q)
	);

	// shifted products
	logic signed [MUL_P_W-1:0] p_sh12, p_sh15, p_sh16, p_sh23, p_shfb;
	assign p_sh12 = p_q >>> 12;
	assign p_sh15 = p_q >>> 15;
	assign p_sh16 = p_q >>> 16;
	assign p_sh23 = p_q >>> 23;
	assign p_shfb = p_q >>> FB;

	// combinational step values
	logic signed [31:0] gain_v;
	logic [32:0]        gain_mag;
	logic signed [31:0] h_v;
	logic signed [36:0] d_v;
	logic               over;
	logic [TL-1:0]      tidx;
	logic signed [TANH_W-1:0] r_v;
	logic signed [31:0] c_v;
	logic signed [39:0] o_wide;
	logic [SAMPLE_BITS-1:0] o_v;

	assign gain_v   = sat32(40'(p_sh12));
	assign gain_mag = gain_v[31] ? 33'(-34'(gain_v)) : 33'(gain_v);
	assign h_v      = sat32(40'(m_q) - 40'(hp_in_q) + 40'(p_sh23));
	assign d_v      = 37'(p_sh12);
	assign over     = |mag_q[35:TANH_POS_FRAC];
	assign tidx     = mag_q[TANH_POS_FRAC-1:FB];
	assign r_v      = over ? t0_q : t0_q + TANH_W'(p_shfb);
	assign c_v      = (drive_q <= BYPASS_DRIVE) ? lp_q :
	                  (neg_q ? -32'(r_v) : 32'(r_v));
	assign o_wide   = 40'(p_sh16);
	always_comb begin
		if (o_wide > OUT_MAX)
			o_v = OUT_MAX[SAMPLE_BITS-1:0];
		else if (o_wide < OUT_MIN)
			o_v = OUT_MIN[SAMPLE_BITS-1:0];
		else
			o_v = o_wide[SAMPLE_BITS-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_MGAIN;
			ST_MGAIN: state_d = ST_GATE;
			ST_GATE:  state_d = ST_MHP;
			ST_MHP:   state_d = ST_HP;
			ST_HP:    state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MLP;
			ST_MLP:   state_d = ST_LP;
			ST_LP:    state_d = ST_MDRV;
			ST_MDRV:  state_d = ST_TIDX;
			ST_TIDX:  state_d = ST_T0;
			ST_T0:    state_d = ST_T1;
			ST_T1:    state_d = ST_TDIF;
			ST_TDIF:  state_d = ST_TM;
			ST_TM:    state_d = ST_TC;
			ST_TC:    state_d = ST_MOUT;
			ST_MOUT:  state_d = ST_Y;
			ST_Y:     state_d = ST_MSIN;
			ST_MSIN:  state_d = ST_G;
			ST_G:     state_d = ST_MG;
			ST_MG:    state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		tanh_addr = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_MGAIN: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(x_q);
				mul_b  = MUL_B_W'({1'b0, input_gain_q});
			end
			ST_MHP: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(hp_out_q);
				mul_b  = MUL_B_W'({1'b0, hp_coeff_q});
			end
			ST_MLP: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(diff_q);
				mul_b  = MUL_B_W'({1'b0, lp_coeff_q});
			end
			ST_MDRV: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(lp_q);
				mul_b  = MUL_B_W'({1'b0, drive_q});
			end
			ST_T0: begin
				tanh_addr = over ? TAW'(TANH_TABLE_DEPTH) : TAW'(tidx);
			end
			ST_T1: begin
				tanh_addr = over ? TAW'(TANH_TABLE_DEPTH) : TAW'(tidx) + TAW'(1);
			end
			ST_TM: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(tdif_q);
				mul_b  = MUL_B_W'({1'b0, mag_q[FB-1:0]});
			end
			ST_MOUT: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(c_q);
				mul_b  = MUL_B_W'({1'b0, out_scale_q});
			end
			ST_MSIN: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(sine_q);
				mul_b  = MUL_B_W'({1'b0, tremolo_depth_q});
			end
			ST_MG: begin
				mul_en = 1'b1;
				mul_a  = y_q;
				mul_b  = MUL_B_W'(g_q);
			end
			ST_OUT: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			input_gain_q     <= 16'd4096;
			gate_threshold_q <= 23'd0;
			hp_coeff_q       <= 23'd8377637;
			lp_coeff_q       <= 23'd8388607;
			drive_q          <= 16'd4096;
			out_scale_q      <= 16'd4096;
			tremolo_depth_q  <= 16'd0;
			tremolo_step_q   <= 32'd8948;
			hp_in_q          <= '0;
			hp_out_q         <= '0;
			lp_q             <= '0;
			phase_q          <= '0;
			m_tvalid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_INPUT_GAIN:    input_gain_q     <= wr_data[15:0];
					REG_GATE_THRESH:   gate_threshold_q <= wr_data[22:0];
					REG_HP_COEFF:      hp_coeff_q       <= wr_data[22:0];
					REG_LP_COEFF:      lp_coeff_q       <= wr_data[22:0];
					REG_DRIVE:         drive_q          <= wr_data[15:0];
					REG_OUT_SCALE:     out_scale_q      <= wr_data[15:0];
					REG_TREMOLO_DEPTH: tremolo_depth_q  <= wr_data[15:0];
					REG_TREMOLO_STEP:  tremolo_step_q   <= wr_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_HP) begin
				hp_in_q  <= m_q;
				hp_out_q <= h_v;
			end
			if (state_q == ST_LP)
				lp_q <= sat32(40'(lp_q) + 40'(p_sh23));
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				phase_q    <= phase_q + tremolo_step_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: x_q <= s_tdata[SAMPLE_BITS-1:0];
			ST_GATE: m_q <= (gain_mag < 33'(gate_threshold_q)) ? '0 : gain_v;
			ST_DIFF: diff_q <= 33'(hp_out_q) - 33'(lp_q);
			ST_TIDX: begin
				neg_q <= d_v[36];
				mag_q <= d_v[36] ? 36'(-d_v) : 36'(d_v);
			end
			ST_T1:   t0_q <= tanh_q;
			ST_TDIF: tdif_q <= tanh_q - t0_q;
			ST_TC:   c_q <= c_v;
			ST_Y:    y_q <= 36'(p_sh12);
			ST_G:    g_q <= 19'sd65536 - 19'(tremolo_depth_q) + 19'(p_sh15);
			ST_OUT:  if (out_load) m_data_q <= o_v;
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'(m_data_q);

endmodule

`default_nettype wire

/* dv/audio_gate_filter_clip_tremolo_tb.sv */
// ----------------------------------------------------------------------------
// audio_gate_filter_clip_tremolo_tb
// Drives samples through the gate, filter, saturation and tremolo block under
// several register settings and random stalls on both streams, predicts each
// output sample with a bit-exact fixed-point model and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_gate_filter_clip_tremolo_tb;
	import agfct_pkg::*;

	localparam int SB = AGF_SAMPLE_BITS;

	class sample_scoreboard;
		longint sine_rom[AGF_SINE_DEPTH];
		longint tanh_rom[AGF_TANH_DEPTH+1];
		longint gain_in, gate_th, hp_r, lp_a, drv, oscale, depth, step;
		longint hp_in, hp_out, lp_out, phase;
		logic [SB-1:0] pending_out[$];
		int errors;

		function new();
			for (int i = 0; i < AGF_SINE_DEPTH; i++)
				sine_rom[i] = sine_entry(AGF_SINE_DEPTH, i);
			for (int i = 0; i <= AGF_TANH_DEPTH; i++)
				tanh_rom[i] = tanh_entry(AGF_TANH_DEPTH, i);
			gain_in = 4096; gate_th = 0; hp_r = 8377637; lp_a = 8388607;
			drv = 4096; oscale = 4096; depth = 0; step = 8948;
			hp_in = 0; hp_out = 0; lp_out = 0; phase = 0;
			errors = 0;
		endfunction

		function longint clamp(longint v, int bits);
			longint hi;
			hi = (64'sd1 <<< (bits - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_INPUT_GAIN:    gain_in = v[15:0];
				REG_GATE_THRESH:   gate_th = v[22:0];
				REG_HP_COEFF:      hp_r = v[22:0];
				REG_LP_COEFF:      lp_a = v[22:0];
				REG_DRIVE:         drv = v[15:0];
				REG_OUT_SCALE:     oscale = v[15:0];
				REG_TREMOLO_DEPTH: depth = v[15:0];
				REG_TREMOLO_STEP:  step = v;
				default: ;
			endcase
		endfunction

		function longint tanh_sat(longint d);
			longint mag, pos, idx, r, frac;
			mag = d < 0 ? -d : d;
			pos = mag * AGF_TANH_DEPTH;
			idx = pos >>> 26;
			if (idx >= AGF_TANH_DEPTH)
				r = tanh_rom[AGF_TANH_DEPTH];
			else begin
				frac = pos & ((64'sd1 <<< 26) - 1);
				r = tanh_rom[idx] + (((tanh_rom[idx+1] - tanh_rom[idx]) * frac) >>> 26);
			end
			return d < 0 ? -r : r;
		endfunction

		function void note_sample(logic [SB-1:0] raw);
			longint x, m, mag, h, c, y, g, o;
			x = longint'($signed(raw));
			m = clamp((x * gain_in) >>> 12, 32);
			mag = m < 0 ? -m : m;
			if (mag < gate_th) m = 0;
			h = clamp(m - hp_in + ((hp_r * hp_out) >>> 23), 32);
			hp_in = m; hp_out = h;
			lp_out = clamp(lp_out + ((lp_a * (h - lp_out)) >>> 23), 32);
			c = (drv <= 4137) ? lp_out : tanh_sat((lp_out * drv) >>> 12);
			y = (c * oscale) >>> 12;
			g = 65536 - depth + ((sine_rom[(phase * AGF_SINE_DEPTH) >>> 32] * depth) >>> 15);
			o = clamp((y * g) >>> 16, SB);
			phase = (phase + step) & 64'hffffffff;
			pending_out.push_back(o[SB-1:0]);
		endfunction

		function void check_sample(logic [SB-1:0] got);
			logic [SB-1:0] exp_v;
			if (pending_out.size() == 0) begin
				$error("sample_out: unexpected transaction, actual %0d", $signed(got));
				errors++;
				return;
			end
			exp_v = pending_out.pop_front();
			if (got !== exp_v) begin
				$error("sample_out: expected %0d actual %0d", $signed(exp_v), $signed(got));
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [SB-1:0] s_tdata, m_tdata;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [31:0] wr_data;
	sample_scoreboard sb;
	bit rx_stall_on;

	audio_gate_filter_clip_tremolo u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
		return 0;
	endfunction

	// wr_en drops when the next sample or drain starts
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// s_tvalid stays up into a back-to-back transaction
	task automatic send_sample(logic [SB-1:0] v, bit gaps);
		int n;
		wr_en <= 1'b0;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1; s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wr_en <= 1'b0;
		while (sb.pending_out.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(0, 4))
			0: return SB'($urandom_range(0, 255) - 128);
			1: return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
			default: return SB'($urandom());
		endcase
	endfunction

	// output side: random stalls, checked on each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_sample(m_tdata);
			m_tready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	initial begin
		#4_000_000;
		$display("audio_gate_filter_clip_tremolo test failed");
		$finish;
	end

	initial begin
		logic [SB-1:0] corners[8];
		sb = new();
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0; rx_stall_on = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes of the sample
		corners = '{24'h7fffff, 24'h800000, 24'h000000, 24'hffffff,
			24'h000001, 24'h400000, 24'hc00000, 24'h555555};
		foreach (corners[i]) send_sample(corners[i], 0);
		drain();
		// gate active, max gain overflow, clipping, tremolo depth above full
		write_reg(REG_INPUT_GAIN, 32'd65535);
		write_reg(REG_GATE_THRESH, 32'd100000);
		write_reg(REG_DRIVE, 32'd65535);
		write_reg(REG_TREMOLO_DEPTH, 32'd65535);
		write_reg(REG_TREMOLO_STEP, 32'hffffffff);
		write_reg(REG_HP_COEFF, 32'd8388607);
		write_reg(REG_LP_COEFF, 32'd0);
		write_reg(REG_OUT_SCALE, 32'd65535);
		write_reg(reg_idx_t'(4'd12), 32'd1); // unknown index is ignored
		foreach (corners[i]) send_sample(corners[i], 0);
		send_sample(24'd99, 0);
		drain();
		write_reg(REG_DRIVE, 32'd4137);
		write_reg(REG_LP_COEFF, 32'd8388607);
		write_reg(REG_GATE_THRESH, 32'd8388607);
		for (int i = 0; i < 4; i++) send_sample(corners[i], 0);
		drain();

		// random phases with random settings
		rx_stall_on = 1'b1;
		for (int p = 0; p < 9; p++) begin
			write_reg(REG_INPUT_GAIN, p == 0 ? 32'd0 : $urandom_range(0, 65535));
			write_reg(REG_GATE_THRESH, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8388607)
				: $urandom_range(0, 20000));
			write_reg(REG_HP_COEFF, p == 1 ? 32'd0 : $urandom_range(0, 8388607));
			write_reg(REG_LP_COEFF, $urandom_range(0, 8388607));
			write_reg(REG_DRIVE, p == 2 ? 32'd4138 : $urandom_range(4096, 65535));
			write_reg(REG_OUT_SCALE, p == 3 ? 32'd0 : $urandom_range(0, 65535));
			write_reg(REG_TREMOLO_DEPTH, p == 4 ? 32'd32768 : $urandom_range(0, 65535));
			write_reg(REG_TREMOLO_STEP, $urandom());
			rx_stall_on = (p % 3) != 0;
			for (int i = 0; i < 100; i++) send_sample(rand_sample(), (p % 4) != 1);
			drain();
		end

		if (sb.errors == 0 && sb.pending_out.size() == 0)
			$display("audio_gate_filter_clip_tremolo test passed");
		else
			$display("audio_gate_filter_clip_tremolo test failed");
		$finish;
	end
endmodule
